// ===== hw/rtl/wfc_pkg.sv =====
// Package: shared constants, types and character classification for the word counter
package wfc_pkg;

  localparam int TableSlotsDef = 32;
  localparam int WordCharsDef  = 16;
  localparam int CharW   = 8;
  localparam int TallyW  = 16;
  localparam int SlotW   = 5;
  localparam int CountW  = 6;
  localparam logic [TallyW-1:0] TallyMax = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_CHAR  = 2'd2
  } kind_t;

  // Hit report handed along the chain of slot cells
  typedef struct packed {
    logic              hit;
    logic [TallyW-1:0] tally;
  } cell_res_t;

  function automatic logic is_punct(input logic [CharW-1:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic kind_t classify(input logic [CharW-1:0] c);
    kind_t k;
    if (c == 8'd0) k = KIND_DROP;
    else if (c == 8'd44 || c == 8'd32 || c == 8'd10 || c == 8'd39) k = KIND_DELIM;
    else if (is_punct(c)) k = KIND_DROP;
    else k = KIND_CHAR;
    return k;
  endfunction

  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
    logic [CharW-1:0] f;
    f = c;
    if (c >= 8'd65 && c <= 8'd90) f = c + 8'd32;
    return f;
  endfunction

endpackage

// ===== hw/rtl/wfc_if.sv =====
// Interfaces: character input channel and result channel
interface wfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface wfc_out_if;
  logic       valid;
  logic       ready;
  logic       word_valid;
  logic [4:0] word_slot;
  logic [15:0] word_tally;
  logic       new_word;
  logic       table_full;
  logic       word_truncated;
  logic       sentence_done;
  logic [5:0] distinct_words;
  modport source (output valid, word_valid, word_slot, word_tally, new_word, table_full,
                  word_truncated, sentence_done, distinct_words, input ready);
  modport sink   (input valid, word_valid, word_slot, word_tally, new_word, table_full,
                  word_truncated, sentence_done, distinct_words, output ready);
endinterface

// ===== hw/rtl/wfc_cell.sv =====
// Slot cell: holds one stored word and its count, compares and updates in place
module wfc_cell #(
  parameter int WORD_CHARS = wfc_pkg::WordCharsDef,
  parameter int LenW       = $clog2(WORD_CHARS + 1)
) (
  input  logic                               clk,
  input  logic                               occupied,
  input  logic [WORD_CHARS*wfc_pkg::CharW-1:0] word,
  input  logic [LenW-1:0]                    word_len,
  input  logic                               lookup,
  input  logic                               alloc,
  input  wfc_pkg::cell_res_t                 res_in,
  output wfc_pkg::cell_res_t                 res_out
);
  import wfc_pkg::*;

  logic [WORD_CHARS*CharW-1:0] text_r;
  logic [LenW-1:0]             len_r;
  logic [TallyW-1:0]           count_r;
  logic                        match;
  logic [TallyW-1:0]           count_inc;

  // Buffer is zero beyond its length, so a whole-word compare suffices
  assign match     = occupied && (len_r == word_len) && (text_r == word);
  assign count_inc = (count_r == TallyMax) ? count_r : count_r + 1'b1;

  // First hit along the chain wins
  always_comb begin
    res_out = res_in;
    if (!res_in.hit && match) begin
      res_out.hit   = 1'b1;
      res_out.tally = count_inc;
    end
  end

  // Storage update
  always_ff @(posedge clk) begin
    if (alloc) begin
      text_r  <= word;
      len_r   <= word_len;
      count_r <= {{(TallyW-1){1'b0}}, 1'b1};
    end else if (lookup && match && !res_in.hit) begin
      count_r <= count_inc;
    end
  end
endmodule

// ===== hw/rtl/word_frequency_counter_unit.sv =====
// The result word of an accepted character is in the output register in the next cycle.
// Throughput: one character per cycle; all slot cells compare the buffered word at once.
// A new character is taken while the output register holds a word only if it is taken too.
// Reset (rst_n low, synchronous) empties the word buffer, the table occupancy count and the output valid flag;
// slot contents are left as they are and read only once written.
// Top level: character classification, word buffer, slot cell chain and output register
module word_frequency_counter_unit #(
  parameter int TABLE_SLOTS = wfc_pkg::TableSlotsDef,
  parameter int WORD_CHARS  = wfc_pkg::WordCharsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  wfc_in_if.sink       in_ch,
  wfc_out_if.source    out_ch
);
  import wfc_pkg::*;

  localparam int LenW  = $clog2(WORD_CHARS + 1);
  localparam int UsedW = $clog2(TABLE_SLOTS + 1);
  localparam int IdxW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [WORD_CHARS*CharW-1:0] buf_r, buf_nxt;
  logic [LenW-1:0]             len_r, len_nxt;
  logic                        over_r, over_nxt;
  logic [UsedW-1:0]            used_r, used_nxt;
  logic                        ovalid_r;

  logic        acc, complete, last, lookup, fresh, full;
  kind_t       kind;
  logic [CharW-1:0] folded;
  logic [WORD_CHARS*CharW-1:0] word_now;
  logic [LenW-1:0]             len_now;
  logic                        over_now;
  cell_res_t chain [TABLE_SLOTS+1];
  logic [TABLE_SLOTS-1:0] hit_vec;
  logic [IdxW-1:0] hit_idx;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign acc  = in_ch.valid && in_ch.ready;
  assign last = in_ch.last_char;
  assign kind   = classify(in_ch.char_code);
  assign folded = fold(in_ch.char_code);

  // Append a word character to the buffer, or flag the word as overlong when the buffer is full
  always_comb begin
    word_now = buf_r;
    len_now  = len_r;
    over_now = over_r;
    if (kind == KIND_CHAR) begin
      if (len_r < LenW'(WORD_CHARS)) begin
        word_now[len_r[LenW-1:0]*CharW +: CharW] = folded;
        len_now = len_r + 1'b1;
      end else begin
        over_now = 1'b1;
      end
    end
  end

  assign complete = (kind == KIND_DELIM || last) && (len_now != '0);
  assign lookup   = acc && complete;

  // Chain of slot cells
  assign chain[0] = '0;
  genvar g;
  generate
    for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      logic prev_hit;
      assign prev_hit = chain[g].hit;
      wfc_cell #(.WORD_CHARS(WORD_CHARS), .LenW(LenW)) u_cell (
        .clk      (clk),
        .occupied (UsedW'(g) < used_r),
        .word     (word_now),
        .word_len (len_now),
        .lookup   (lookup),
        .alloc    (lookup && !chain[TABLE_SLOTS].hit && used_r == UsedW'(g)),
        .res_in   (chain[g]),
        .res_out  (chain[g+1])
      );
      assign hit_vec[g] = chain[g+1].hit && !prev_hit;
    end
  endgenerate

  // Encode the winning slot
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (hit_vec[i]) hit_idx = IdxW'(i);
  end

  assign fresh = complete && !chain[TABLE_SLOTS].hit && (used_r < UsedW'(TABLE_SLOTS));
  assign full  = complete && !chain[TABLE_SLOTS].hit && !(used_r < UsedW'(TABLE_SLOTS));

  // Next buffer and occupancy
  always_comb begin
    buf_nxt  = word_now;
    len_nxt  = len_now;
    over_nxt = over_now;
    used_nxt = used_r + (fresh ? UsedW'(1) : UsedW'(0));
    if (complete || last) begin
      buf_nxt  = '0;
      len_nxt  = '0;
      over_nxt = 1'b0;
    end
    if (last) used_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r    <= '0;
      len_r    <= '0;
      over_r   <= 1'b0;
      used_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        buf_r  <= buf_nxt;
        len_r  <= len_nxt;
        over_r <= over_nxt;
        used_r <= used_nxt;
      end
      if (acc && (complete || last)) ovalid_r <= 1'b1;
      else if (out_ch.ready)         ovalid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (acc && (complete || last)) begin
      out_ch.word_valid     <= complete;
      out_ch.word_slot      <= chain[TABLE_SLOTS].hit ? SlotW'(hit_idx) :
                               fresh ? SlotW'(used_r) : '0;
      out_ch.word_tally     <= chain[TABLE_SLOTS].hit ? chain[TABLE_SLOTS].tally :
                               fresh ? TallyW'(1) : '0;
      out_ch.new_word       <= fresh;
      out_ch.table_full     <= full;
      out_ch.word_truncated <= complete && over_now;
      out_ch.sentence_done  <= last;
      out_ch.distinct_words <= CountW'(used_r + (fresh ? UsedW'(1) : UsedW'(0)));
    end
  end

  assign out_ch.valid = ovalid_r;
endmodule

// ===== hw/rtl/wfc_checker.sv =====
// Checker: port-level properties of the word counter, bound to the top level
module wfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        word_valid,
  input logic        new_word,
  input logic        table_full,
  input logic [15:0] word_tally
);
  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Input is taken whenever the output can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("input stalled needlessly");
  // A fresh word has a tally of one
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && new_word |-> word_tally == 16'd1 && word_valid) else $error("bad fresh tally");
  // Fresh and full never together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(new_word && table_full)) else $error("fresh and full");
endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_valid(out_ch.word_valid), .new_word(out_ch.new_word),
  .table_full(out_ch.table_full), .word_tally(out_ch.word_tally)
);

// ===== verif/tb_word_frequency_counter_unit.sv =====
// Testbench: streams sentences into the word counter and checks every result word
`timescale 1ns / 1ps

module tb_word_frequency_counter_unit;
  import wfc_pkg::*;

  localparam int NSlots = TableSlotsDef;
  localparam int NChars = WordCharsDef;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    logic        word_valid;
    logic [4:0]  word_slot;
    logic [15:0] word_tally;
    logic        new_word;
    logic        table_full;
    logic        word_truncated;
    logic        sentence_done;
    logic [5:0]  distinct_words;
  } tally_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wfc_in_if  in_ch ();
  wfc_out_if out_ch ();

  word_frequency_counter_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [7:0]  cur_text [NChars];
  int          cur_len;
  logic        cur_long;
  logic [7:0]  slot_text [NSlots][NChars];
  int          slot_len [NSlots];
  logic [15:0] slot_count [NSlots];
  int          n_used;

  char_word_t  char_queue [$];
  tally_word_t tally_queue [$];
  int          n_errors = 0;
  int          n_cycles = 0;

  // Stimulus control
  bit quiet_phase = 1'b0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;
  bit in_acc = 1'b0;
  int hold_cycles = 0;
  int src_gap = 0;
  int snk_gap = 0;

  // Works out the result of one accepted character, if any
  task automatic count_char(input char_word_t w);
    kind_t       k;
    logic [7:0]  f;
    bit          done, hit, same;
    int          s, i;
    tally_word_t r;
    k = classify(w.char_code);
    f = (w.char_code >= 8'd65 && w.char_code <= 8'd90) ? w.char_code + 8'd32 : w.char_code;
    r = '0;
    if (k == KIND_CHAR) begin
      if (cur_len < NChars) begin
        cur_text[cur_len] = f;
        cur_len++;
      end else cur_long = 1'b1;
    end
    done = (k == KIND_DELIM || w.last_char) && cur_len > 0;
    if (done) begin
      hit = 1'b0;
      r.word_valid = 1'b1;
      r.word_truncated = cur_long;
      for (s = 0; s < n_used && !hit; s++) begin
        same = (slot_len[s] == cur_len);
        for (i = 0; i < cur_len; i++) if (slot_text[s][i] != cur_text[i]) same = 1'b0;
        if (same) begin
          hit = 1'b1;
          if (slot_count[s] != 16'hFFFF) slot_count[s]++;
          r.word_slot = s[4:0];
          r.word_tally = slot_count[s];
        end
      end
      if (!hit) begin
        if (n_used < NSlots) begin
          for (i = 0; i < cur_len; i++) slot_text[n_used][i] = cur_text[i];
          slot_len[n_used] = cur_len;
          slot_count[n_used] = 16'd1;
          r.word_slot = n_used[4:0];
          r.word_tally = 16'd1;
          r.new_word = 1'b1;
          n_used++;
        end else r.table_full = 1'b1;
      end
      cur_len = 0;
      cur_long = 1'b0;
    end
    if (done || w.last_char) begin
      r.sentence_done = w.last_char;
      r.distinct_words = n_used[5:0];
      tally_queue.push_back(r);
    end
    if (w.last_char) begin
      n_used = 0;
      cur_len = 0;
      cur_long = 1'b0;
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic l);
    char_word_t w;
    w.char_code = c;
    w.last_char = l;
    char_queue.push_back(w);
  endtask

  task automatic push_text(input string t, input bit l);
    int i;
    for (i = 0; i < t.len(); i++) push_char(t[i], l && i == t.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'd97 + 8'($urandom_range(0, 5)) - (($urandom_range(0, 3) == 0) ? 8'd32 : 8'd0);
  endfunction

  // Random sentence: mostly short words from a small alphabet, some noise
  task automatic push_sentence(input int n_words, input int max_len);
    int i, j, n;
    for (i = 0; i < n_words; i++) begin
      n = $urandom_range(1, max_len);
      for (j = 0; j < n; j++) begin
        if ($urandom_range(0, 9) == 0) push_char(8'($urandom), 1'b0);
        else push_char(rand_letter(), 1'b0);
      end
      case ($urandom_range(0, 4))
        0: push_char(8'd44, 1'b0);
        1: push_char(8'd10, 1'b0);
        2: push_char(8'd39, 1'b0);
        default: push_char(8'd32, 1'b0);
      endcase
    end
    push_char($urandom_range(0, 1) ? rand_letter() : 8'd46, 1'b1);
  endtask

  // Acceptance at the rising edge: predict the result of the taken word
  always @(posedge clk) begin
    in_acc = rst_n && in_ch.valid && in_ch.ready;
    if (in_acc) count_char(char_queue.pop_front());
  end

  // Sender: drives at the falling edge, holds an offered word until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_acc)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
        src_gap = $urandom_range(1, 11);
        in_ch.valid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.char_code <= char_queue[0].char_code;
        in_ch.last_char <= char_queue[0].last_char;
      end else in_ch.valid <= 1'b0;
    end
  end

  // Receiver: checks each result word at the rising edge
  always @(posedge clk) begin
    tally_word_t a, e;
    n_cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = '{out_ch.word_valid, out_ch.word_slot, out_ch.word_tally, out_ch.new_word,
            out_ch.table_full, out_ch.word_truncated, out_ch.sentence_done,
            out_ch.distinct_words};
      if (tally_queue.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = tally_queue.pop_front();
        if (a.word_valid !== e.word_valid) begin
          $error("word_valid exp %0d got %0d", e.word_valid, a.word_valid); n_errors++; end
        if (a.word_slot !== e.word_slot) begin
          $error("word_slot exp %0d got %0d", e.word_slot, a.word_slot); n_errors++; end
        if (a.word_tally !== e.word_tally) begin
          $error("word_tally exp %0d got %0d", e.word_tally, a.word_tally); n_errors++; end
        if (a.new_word !== e.new_word) begin
          $error("new_word exp %0d got %0d", e.new_word, a.new_word); n_errors++; end
        if (a.table_full !== e.table_full) begin
          $error("table_full exp %0d got %0d", e.table_full, a.table_full); n_errors++; end
        if (a.word_truncated !== e.word_truncated) begin
          $error("word_truncated exp %0d got %0d", e.word_truncated, a.word_truncated);
          n_errors++;
        end
        if (a.sentence_done !== e.sentence_done) begin
          $error("sentence_done exp %0d got %0d", e.sentence_done, a.sentence_done);
          n_errors++;
        end
        if (a.distinct_words !== e.distinct_words) begin
          $error("distinct_words exp %0d got %0d", e.distinct_words, a.distinct_words);
          n_errors++;
        end
      end
    end
    if (n_cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stalls, including one long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_start && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 60) hold_done = 1'b1;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
      snk_gap = $urandom_range(1, 11);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  initial begin
    int i;
    cur_len = 0;
    cur_long = 1'b0;
    n_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: case folding, punctuation, delimiters, zero byte, high codes
    push_text("Hi, hi'HI x.y!", 1'b0);
    push_char(8'd0, 1'b0);
    push_char(8'd255, 1'b0);
    push_char(8'd128, 1'b0);
    push_char(8'd1, 1'b0);
    push_char(8'd10, 1'b0);
    push_char(8'd32, 1'b1);                  // end without a pending word
    push_text("abcdefghijklmnopqrstu z", 1'b1); // overlong word, then end on a word
    push_char(8'd127, 1'b1);                 // one-character sentence
    // Table full: more distinct words than slots in one sentence
    for (i = 0; i < NSlots + 2; i++) begin
      push_char(8'd97 + 8'(i / 26), 1'b0);
      push_char(8'd97 + 8'(i % 26), 1'b0);
      push_char(8'd32, 1'b0);
    end
    push_text("aa", 1'b1);

    // Sender pauses until everything has drained
    wait (char_queue.size() == 0 && tally_queue.size() == 0);
    @(posedge clk);

    // Receiver holds off long while characters keep coming
    hold_start = 1'b1;
    for (i = 0; i < 6; i++) push_sentence(6, 4);

    // Random bulk
    while (char_queue.size() < 260) begin
      if ($urandom_range(0, 9) == 0) push_sentence($urandom_range(1, 4), 20);
      else push_sentence($urandom_range(1, 12), 4);
    end
    wait (char_queue.size() < 40);
    quiet_phase = 1'b1;
    for (i = 0; i < 3; i++) push_sentence(4, 3);

    wait (char_queue.size() == 0 && !(in_ch.valid === 1'b1));
    wait (tally_queue.size() == 0);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && tally_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
